/* hdl/ecd_pkg.sv */
// Shared constants and table builders for the epoch-to-calendar-date unit.
// Depends on nothing; imported by epoch_to_calendar_date_unit.
`default_nettype none

package ecd_pkg;

  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned NUM_YEARS  = 137;  // 1970 through 2106

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned SOH_W   = 12;
  localparam int unsigned YIDX_W  = 8;
  localparam int unsigned DOY_W   = 9;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  // 86400 = 2^7 * 675; the low seven bits are dropped before the reciprocal.
  // The floored reciprocal gives a quotient that is exact or one low.
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_ODD       = SECS_PER_DAY >> DAY_PRE_SHIFT;
  localparam int unsigned DAY_K         = 35;
  localparam int unsigned DAY_RECIP_W   = 26;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
    DAY_RECIP_W'((64'd1 << DAY_K) / DAY_ODD);

  // Rounded-up reciprocals; exact over the value ranges that reach them.
  localparam int unsigned YEAR_K       = 24;
  localparam int unsigned YEAR_RECIP_W = 16;
  localparam logic [YEAR_RECIP_W-1:0] YEAR_RECIP =
    YEAR_RECIP_W'(((64'd1 << YEAR_K) + 64'd364) / 64'd365);

  localparam int unsigned HOUR_K       = 28;
  localparam int unsigned HOUR_RECIP_W = 17;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
    HOUR_RECIP_W'(((64'd1 << HOUR_K) + SECS_PER_HOUR - 1) / SECS_PER_HOUR);

  localparam int unsigned MIN_K       = 18;
  localparam int unsigned MIN_RECIP_W = 13;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
    MIN_RECIP_W'(((64'd1 << MIN_K) + SECS_PER_MIN - 1) / SECS_PER_MIN);

  typedef logic [DAYS_W-1:0] year_start_t [0:NUM_YEARS-1];
  typedef logic [DOY_W-1:0]  month_base_t [0:11];

  localparam month_base_t MONTH_BASE = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Full Gregorian rule, used only while building tables.
  function automatic logic is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic year_start_t build_year_start();
    year_start_t tbl;
    int unsigned acc;
    acc = 0;
    for (int unsigned i = 0; i < NUM_YEARS; i++) begin
      tbl[i] = acc[DAYS_W-1:0];
      acc    = acc + (is_leap(FIRST_YEAR + i) ? 366 : 365);
    end
    return tbl;
  endfunction

  // Day number (from zero) at which each year starts.
  localparam year_start_t YEAR_START = build_year_start();

  localparam logic [YEAR_W-1:0] YEAR_BASE    = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0] CENTURY_SKIP = YEAR_W'(2100);

  // Within 1970..2106 the only year divisible by 4 that is not a leap
  // year is 2100 (2000 is divisible by 400).
  function automatic logic leap_of_index(logic [YIDX_W-1:0] idx);
    logic [YEAR_W-1:0] y;
    y = YEAR_BASE + YEAR_W'(idx);
    return (y[1:0] == 2'b00) && (y != CENTURY_SKIP);
  endfunction

  function automatic logic [DOY_W-1:0] month_start(logic [MONTH_W-1:0] m,
                                                   logic leap);
    logic [DOY_W-1:0] base;
    base = (m < MONTH_W'(12)) ? MONTH_BASE[m] : '0;
    if (leap && (m >= MONTH_W'(2))) begin
      base = base + DOY_W'(1);
    end
    return base;
  endfunction

endpackage

`default_nettype wire

/* hdl/epoch_to_calendar_date_unit.sv */
// Top level: Unix epoch seconds to Gregorian date and time of day.
// Depends on ecd_pkg for constants, reciprocals and the year-start table.
//
//   Channel   Handshake             Word
//   -------   -------------------   ----------------------------------------
//   input     in_valid / in_ready   epoch_seconds
//   output    out_valid / out_ready year, month, day_of_month, hour, minute,
//                                   second
//
// The unit is an eight-stage pipeline and takes one word every cycle unless a stall
// at the output holds it. The depth is set by the chain of constant-reciprocal
// multiplies (day split, year estimate, hour, minute), each followed by a register
// and a correction stage; the year and hour multiplies share theirs.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage holds when it is full and the stage after it cannot take its
// word, so a stall at the output fills bubbles first and loses nothing.
`default_nettype none

module epoch_to_calendar_date_unit
  import ecd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [EPOCH_W-1:0]  epoch_seconds,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [YEAR_W-1:0]        year,
  output logic [MONTH_W-1:0]       month,
  output logic [DAY_W-1:0]         day_of_month,
  output logic [HOUR_W-1:0]        hour,
  output logic [MINUTE_W-1:0]      minute,
  output logic [SECOND_W-1:0]      second
);

  localparam int unsigned NUM_STAGES = 8;

  // Stage valid bits and per-stage load enables.
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] en;

  // A stage may load when it is empty or when its word moves on this cycle.
  always_comb begin
    en[NUM_STAGES] = !v[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: capture the timestamp.
  logic [EPOCH_W-1:0] s1_secs;

  // Stage 2: day quotient estimate, exact or one low.
  logic [EPOCH_W-1:0] s2_secs;
  logic [DAYS_W-1:0]  s2_qest;

  // Stage 3: back-multiplied estimate.
  logic [EPOCH_W-1:0] s3_secs;
  logic [DAYS_W-1:0]  s3_qest;
  logic [EPOCH_W-1:0] s3_qprod;

  // Stage 4: corrected whole days and seconds of the day.
  logic [DAYS_W-1:0]  s4_days;
  logic [SOD_W-1:0]   s4_sod;

  // Stage 5: year index estimate and hour.
  logic [DAYS_W-1:0]  s5_days;
  logic [YIDX_W-1:0]  s5_yest;
  logic [SOD_W-1:0]   s5_sod;
  logic [HOUR_W-1:0]  s5_hour;

  // Stage 6: final year, day of year, seconds of the hour.
  logic [YIDX_W-1:0]  s6_yidx;
  logic               s6_leap;
  logic [DOY_W-1:0]   s6_doy;
  logic [HOUR_W-1:0]  s6_hour;
  logic [SOH_W-1:0]   s6_soh;

  // Stage 7: month found, minute computed.
  logic [YIDX_W-1:0]  s7_yidx;
  logic [DOY_W-1:0]   s7_doy;
  logic [DOY_W-1:0]   s7_mstart;
  logic [MONTH_W-1:0] s7_mon;
  logic [HOUR_W-1:0]  s7_hour;
  logic [SOH_W-1:0]   s7_soh;
  logic [MINUTE_W-1:0] s7_minute;

  // Combinational values between stages.
  logic [DAY_RECIP_W+EPOCH_W-DAY_PRE_SHIFT-1:0] day_prod;
  logic [EPOCH_W:0]                             qprod_full;
  logic [EPOCH_W-1:0]                           day_diff;
  logic [SOD_W:0]                               rem_raw;
  logic                                         rem_over;
  logic [DAYS_W+YEAR_RECIP_W-1:0]               year_prod;
  logic [SOD_W+HOUR_RECIP_W-1:0]                hour_prod;
  logic [YIDX_W-1:0]                            yidx_hi;
  logic [YIDX_W-1:0]                            yidx_lo;
  logic [DAYS_W-1:0]                            ystart_hi;
  logic [DAYS_W-1:0]                            ystart_lo;
  logic                                         year_low;
  logic [YIDX_W-1:0]                            yidx_sel;
  logic [DAYS_W-1:0]                            ystart_sel;
  logic [DAYS_W-1:0]                            doy_full;
  logic [SOD_W-1:0]                             hour_secs;
  logic [SOD_W-1:0]                             soh_full;
  logic [MONTH_W-1:0]                           mon_sel;
  logic [SOH_W+MIN_RECIP_W-1:0]                 min_prod;
  logic [SOH_W-1:0]                             min_secs;
  logic [SOH_W-1:0]                             sec_full;
  logic [DOY_W-1:0]                             dom_full;

  always_comb begin
    // Days: drop the power-of-two factor, then multiply by 2^35 / 675.
    day_prod = s1_secs[EPOCH_W-1:DAY_PRE_SHIFT] * DAY_RECIP;

    qprod_full = s2_qest * SOD_W'(SECS_PER_DAY);

    // The remainder is below twice a day, so one compare settles it.
    day_diff = s3_secs - s3_qprod;
    rem_raw  = day_diff[SOD_W:0];
    rem_over = rem_raw >= (SOD_W+1)'(SECS_PER_DAY);

    year_prod = s4_days * YEAR_RECIP;
    hour_prod = s4_sod * HOUR_RECIP;

    // The true year index is the estimate floor(days/365) or one below it.
    yidx_hi    = (s5_yest > YIDX_W'(NUM_YEARS - 1)) ? YIDX_W'(NUM_YEARS - 1)
                                                     : s5_yest;
    yidx_lo    = (yidx_hi == '0) ? '0 : yidx_hi - YIDX_W'(1);
    ystart_hi  = YEAR_START[yidx_hi];
    ystart_lo  = YEAR_START[yidx_lo];
    year_low   = s5_days < ystart_hi;
    yidx_sel   = year_low ? yidx_lo : yidx_hi;
    ystart_sel = year_low ? ystart_lo : ystart_hi;
    doy_full   = s5_days - ystart_sel;
    hour_secs  = SOD_W'(s5_hour * SOD_W'(SECS_PER_HOUR));
    soh_full   = s5_sod - hour_secs;

    // Month: last month whose start is not past the day of year.
    mon_sel = '0;
    for (int m = 1; m < 12; m++) begin
      if (s6_doy >= month_start(MONTH_W'(m), s6_leap)) begin
        mon_sel = MONTH_W'(m);
      end
    end
    min_prod = s6_soh * MIN_RECIP;

    min_secs = SOH_W'(s7_minute * SOH_W'(SECS_PER_MIN));
    sec_full = s7_soh - min_secs;
    dom_full = s7_doy - s7_mstart + DOY_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_secs <= epoch_seconds;
    end
    if (en[2]) begin
      s2_secs <= s1_secs;
      s2_qest <= day_prod[DAY_K +: DAYS_W];
    end
    if (en[3]) begin
      s3_secs  <= s2_secs;
      s3_qest  <= s2_qest;
      s3_qprod <= qprod_full[EPOCH_W-1:0];
    end
    if (en[4]) begin
      if (rem_over) begin
        s4_days <= s3_qest + DAYS_W'(1);
        s4_sod  <= SOD_W'(rem_raw - (SOD_W+1)'(SECS_PER_DAY));
      end else begin
        s4_days <= s3_qest;
        s4_sod  <= rem_raw[SOD_W-1:0];
      end
    end
    if (en[5]) begin
      s5_days <= s4_days;
      s5_yest <= year_prod[YEAR_K +: YIDX_W];
      s5_sod  <= s4_sod;
      s5_hour <= hour_prod[HOUR_K +: HOUR_W];
    end
    if (en[6]) begin
      s6_yidx <= yidx_sel;
      s6_leap <= leap_of_index(yidx_sel);
      s6_doy  <= doy_full[DOY_W-1:0];
      s6_hour <= s5_hour;
      s6_soh  <= soh_full[SOH_W-1:0];
    end
    if (en[7]) begin
      s7_yidx   <= s6_yidx;
      s7_doy    <= s6_doy;
      s7_mstart <= month_start(mon_sel, s6_leap);
      s7_mon    <= mon_sel;
      s7_hour   <= s6_hour;
      s7_soh    <= s6_soh;
      s7_minute <= min_prod[MIN_K +: MINUTE_W];
    end
    if (en[8]) begin
      year         <= YEAR_BASE + YEAR_W'(s7_yidx);
      month        <= s7_mon + MONTH_W'(1);
      day_of_month <= dom_full[DAY_W-1:0];
      hour         <= s7_hour;
      minute       <= s7_minute;
      second       <= sec_full[SECOND_W-1:0];
    end
  end

endmodule

`default_nettype wire
